// ===== rtl/hpc_pkg.sv =====
// shared types and constants for the hysteresis peak counter
// no dependencies; imported by every module of the block
`default_nettype none

package hpc_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int THR_BITS    = 16;
    localparam int CNT_BITS    = 8;
    localparam int CMP_BITS    = (SAMPLE_BITS > THR_BITS) ? SAMPLE_BITS : THR_BITS;
    localparam int DWELL_BITS  = 9;
    localparam int RUN_BITS    = 17;
    localparam int PEAK_BITS   = 16;
    localparam int CFG_IDX_BITS = 3;

    localparam logic [DWELL_BITS-1:0] DWELL_MAX = {DWELL_BITS{1'b1}};
    localparam logic [RUN_BITS-1:0]   RUN_MAX   = {RUN_BITS{1'b1}};
    localparam logic [PEAK_BITS-1:0]  PEAK_MAX  = {PEAK_BITS{1'b1}};

    // register reset values
    localparam logic [THR_BITS-1:0] IDLE_THR_RST  = THR_BITS'(10);
    localparam logic [THR_BITS-1:0] LOW_THR_RST   = THR_BITS'(20);
    localparam logic [THR_BITS-1:0] HIGH_THR_RST  = THR_BITS'(50);
    localparam logic [THR_BITS-1:0] IDLE_LIM_RST  = THR_BITS'(100);
    localparam logic [CNT_BITS-1:0] MIN_CYC_RST   = CNT_BITS'(3);
    localparam logic [CNT_BITS-1:0] MAX_CYC_RST   = CNT_BITS'(40);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_IDLE_THR  = 3'd0,
        CFG_LOW_THR   = 3'd1,
        CFG_HIGH_THR  = 3'd2,
        CFG_IDLE_LIM  = 3'd3,
        CFG_RISE_MIN  = 3'd4,
        CFG_HIGH_MIN  = 3'd5,
        CFG_FALL_MIN  = 3'd6,
        CFG_MAX_CYC   = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [THR_BITS-1:0] idle_thr;
        logic [THR_BITS-1:0] low_thr;
        logic [THR_BITS-1:0] high_thr;
        logic [THR_BITS-1:0] idle_lim;
        logic [CNT_BITS-1:0] rise_min;
        logic [CNT_BITS-1:0] high_min;
        logic [CNT_BITS-1:0] fall_min;
        logic [CNT_BITS-1:0] max_cyc;
    } t_cfg;

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_RISE = 4'b0010,
        PH_HIGH = 4'b0100,
        PH_FALL = 4'b1000
    } t_phase;

    localparam logic [1:0] CODE_IDLE = 2'd0;
    localparam logic [1:0] CODE_RISE = 2'd1;
    localparam logic [1:0] CODE_HIGH = 2'd2;
    localparam logic [1:0] CODE_FALL = 2'd3;

endpackage

`default_nettype wire

// ===== rtl/hysteresis_peak_counter.sv =====
// top level of the hysteresis peak counter: sample register, config registers, tracker, result register
// depends on hpc_pkg, hpc_cfg_regs and hpc_tracker
`default_nettype none

// One sample in, one result out (peak count and phase after that sample).
// Each beat is held in the sample register and is evaluated by the tracker on
// its way into the result register, and a new sample is taken every cycle
// while the result side keeps up. The tracker's compare-and-count logic
// between the two registers sets the clock. Configuration writes are always
// ready and take effect the next cycle.
module hysteresis_peak_counter
    import hpc_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    output logic                         o_in_stall,
    input  wire logic [SAMPLE_BITS-1:0]  i_sample,
    output logic                         o_out_valid,
    input  wire logic                    i_out_stall,
    output logic [PEAK_BITS-1:0]         o_peak_count,
    output logic [1:0]                   o_phase,
    input  wire logic                    i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  wire logic [THR_BITS-1:0]     i_cfg_data
);

    t_cfg                   cfg;
    logic                   r_in_valid;
    logic [SAMPLE_BITS-1:0] r_sample;
    logic                   r_out_valid;
    logic [PEAK_BITS-1:0]   r_peak_count;
    logic [1:0]             r_phase;
    logic                   out_free, advance, in_take;
    logic [PEAK_BITS-1:0]   trk_peak;
    logic [1:0]             trk_phase;

    assign o_cfg_ready = 1'b1;

    hpc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    hpc_tracker u_trk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (advance),
        .i_sample     (r_sample),
        .i_cfg        (cfg),
        .o_peak_count (trk_peak),
        .o_phase      (trk_phase)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_sample <= i_sample;
        end
        if (advance) begin
            r_peak_count <= trk_peak;
            r_phase      <= trk_phase;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_peak_count = r_peak_count;
    assign o_phase      = r_phase;

endmodule

`default_nettype wire

// ===== rtl/hpc_cfg_regs.sv =====
// configuration register file of the hysteresis peak counter
// depends on hpc_pkg
`default_nettype none

module hpc_cfg_regs
    import hpc_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_valid,
    input  wire logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  wire logic [THR_BITS-1:0]     i_cfg_data,
    output t_cfg                         o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.idle_thr <= IDLE_THR_RST;
            r_cfg.low_thr  <= LOW_THR_RST;
            r_cfg.high_thr <= HIGH_THR_RST;
            r_cfg.idle_lim <= IDLE_LIM_RST;
            r_cfg.rise_min <= MIN_CYC_RST;
            r_cfg.high_min <= MIN_CYC_RST;
            r_cfg.fall_min <= MIN_CYC_RST;
            r_cfg.max_cyc  <= MAX_CYC_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_IDLE_THR: r_cfg.idle_thr <= i_cfg_data;
                CFG_LOW_THR:  r_cfg.low_thr  <= i_cfg_data;
                CFG_HIGH_THR: r_cfg.high_thr <= i_cfg_data;
                CFG_IDLE_LIM: r_cfg.idle_lim <= i_cfg_data;
                CFG_RISE_MIN: r_cfg.rise_min <= i_cfg_data[CNT_BITS-1:0];
                CFG_HIGH_MIN: r_cfg.high_min <= i_cfg_data[CNT_BITS-1:0];
                CFG_FALL_MIN: r_cfg.fall_min <= i_cfg_data[CNT_BITS-1:0];
                CFG_MAX_CYC:  r_cfg.max_cyc  <= i_cfg_data[CNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== rtl/hpc_tracker.sv =====
// phase tracker: phase, dwell, idle run and peak count state with next-state logic
// depends on hpc_pkg
`default_nettype none

module hpc_tracker
    import hpc_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_en,
    input  wire logic [SAMPLE_BITS-1:0] i_sample,
    input  t_cfg                        i_cfg,
    output logic [PEAK_BITS-1:0]        o_peak_count,
    output logic [1:0]                  o_phase
);

    t_phase                r_phase, n_phase;
    logic [DWELL_BITS-1:0] r_dwell, n_dwell;
    logic [RUN_BITS-1:0]   r_idle_run, n_idle_run;
    logic [PEAK_BITS-1:0]  r_peaks, n_peaks;

    logic [CMP_BITS-1:0]   s_ext, idle_ext, low_ext, high_ext;
    logic                  is_idle, run_clear;
    logic [RUN_BITS-1:0]   run_inc;
    logic [DWELL_BITS-1:0] dwell_inc, max_ext, rise_ext, hmin_ext, fall_ext;
    t_phase                ph_eff;

    always_comb begin
        s_ext    = CMP_BITS'(i_sample);
        idle_ext = CMP_BITS'(i_cfg.idle_thr);
        low_ext  = CMP_BITS'(i_cfg.low_thr);
        high_ext = CMP_BITS'(i_cfg.high_thr);
        max_ext  = DWELL_BITS'(i_cfg.max_cyc);
        rise_ext = DWELL_BITS'(i_cfg.rise_min);
        hmin_ext = DWELL_BITS'(i_cfg.high_min);
        fall_ext = DWELL_BITS'(i_cfg.fall_min);

        is_idle = s_ext < idle_ext;
        if (is_idle) begin
            run_inc = (r_idle_run != RUN_MAX) ? r_idle_run + 1'b1 : r_idle_run;
        end else begin
            run_inc = '0;
        end
        run_clear  = run_inc > RUN_BITS'(i_cfg.idle_lim);
        n_idle_run = run_clear ? '0 : run_inc;
        n_peaks    = run_clear ? '0 : r_peaks;
        ph_eff     = is_idle ? PH_IDLE : r_phase;

        dwell_inc = (r_dwell != DWELL_MAX) ? r_dwell + 1'b1 : r_dwell;
        n_dwell   = dwell_inc;
        n_phase   = ph_eff;

        unique case (ph_eff)
            PH_IDLE: begin
                if (s_ext > low_ext && s_ext > idle_ext) begin
                    n_phase = PH_RISE;
                    n_dwell = '0;
                end
            end
            PH_RISE: begin
                if (dwell_inc > max_ext) begin
                    n_phase = PH_IDLE;
                    n_dwell = '0;
                end else if (dwell_inc > rise_ext && s_ext > high_ext) begin
                    n_phase = PH_HIGH;
                    n_dwell = '0;
                end
            end
            PH_HIGH: begin
                if (dwell_inc > max_ext) begin
                    n_phase = PH_IDLE;
                    n_dwell = '0;
                end else if (dwell_inc > hmin_ext && s_ext < high_ext) begin
                    n_phase = PH_FALL;
                    n_dwell = '0;
                    if (n_peaks != PEAK_MAX) begin
                        n_peaks = n_peaks + 1'b1;
                    end
                end
            end
            PH_FALL: begin
                if (dwell_inc > max_ext) begin
                    n_phase = PH_IDLE;
                    n_dwell = '0;
                end else if (dwell_inc > fall_ext && s_ext < low_ext) begin
                    n_phase = PH_IDLE;
                    n_dwell = '0;
                end
            end
            default: begin
                n_phase = PH_IDLE;
                n_dwell = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_dwell    <= '0;
            r_idle_run <= '0;
            r_peaks    <= '0;
        end else if (i_en) begin
            r_phase    <= n_phase;
            r_dwell    <= n_dwell;
            r_idle_run <= n_idle_run;
            r_peaks    <= n_peaks;
        end
    end

    // next-state values go straight to the result register
    always_comb begin
        o_peak_count = n_peaks;
        unique case (n_phase)
            PH_IDLE: o_phase = CODE_IDLE;
            PH_RISE: o_phase = CODE_RISE;
            PH_HIGH: o_phase = CODE_HIGH;
            PH_FALL: o_phase = CODE_FALL;
            default: o_phase = CODE_IDLE;
        endcase
    end

endmodule

`default_nettype wire
